// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the page allocator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFLA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define PFLA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// shared constants and types of the free page list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

   localparam int PAGE_SLOTS = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_BITS  = 56;

   localparam int PN_BITS    = ADDR_BITS - PAGE_SHIFT;
   localparam int SLOT_BITS  = $clog2(PAGE_SLOTS);
   localparam int CNT_BITS   = $clog2(PAGE_SLOTS + 1);
   localparam int BYTES_BITS = 25;
   localparam int CSR_BITS   = 1;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [CSR_BITS-1:0] CSR_POOL_START = 1'd0;
   localparam logic [CSR_BITS-1:0] CSR_POOL_STOP  = 1'd1;

   typedef struct packed {
      logic                 we;
      logic [SLOT_BITS-1:0] waddr;
      logic [PN_BITS-1:0]   wdata;
      logic                 re;
      logic [SLOT_BITS-1:0] raddr;
   } pfla_mem_req_type;

   typedef struct packed {
      logic                busy;
      logic [CNT_BITS-1:0] count;
   } pfla_stat_type;

endpackage

`default_nettype wire

// File: design/pfla_stack_ram.sv
// ----------------------------------------------------------------------------
// pfla_stack_ram
// free page number stack storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_stack_ram
   import pfla_pkg::*;
(
   input  wire logic             clock,
   input  wire pfla_mem_req_type mem_req,
   output logic [PN_BITS-1:0]    rd_data
);

   logic [PN_BITS-1:0] mem [PAGE_SLOTS];
   logic [PN_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// pfla_ctrl
// request sequencer: alloc pop, free push, init fill, response register
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_ctrl
   import pfla_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_type,
   input  wire logic [ADDR_BITS-1:0]  req_page_address,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ADDR_BITS-1:0]       rsp_alloc_address,
   output logic [1:0]                 rsp_status,
   output logic [BYTES_BITS-1:0]      rsp_free_bytes,
   input  wire logic [ADDR_BITS-1:0]  pool_start,
   input  wire logic [ADDR_BITS-1:0]  pool_stop,
   output pfla_mem_req_type           mem_req,
   input  wire logic [PN_BITS-1:0]    mem_rd_data,
   output pfla_stat_type              stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INIT_CALC,
      S_INIT_FILL,
      S_RESP
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [CNT_BITS-1:0]       n_ff, n_in;
   logic [PN_BITS:0]          pn_ff, pn_in;
   logic [PN_BITS:0]          stop_pn_ff, stop_pn_in;
   logic [1:0]                res_status_ff, res_status_in;
   logic                      use_rd_ff, use_rd_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]      rsp_alloc_address_ff, rsp_alloc_address_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [BYTES_BITS-1:0]     rsp_free_bytes_ff, rsp_free_bytes_in;

   logic                      bad_free;
   logic [PN_BITS:0]          span;

   assign bad_free = (req_page_address[PAGE_SHIFT-1:0] != '0) ||
                     (req_page_address < pool_start) ||
                     (req_page_address >= pool_stop);
   assign span     = stop_pn_ff - pn_ff;

   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      n_in                 = n_ff;
      pn_in                = pn_ff;
      stop_pn_in           = stop_pn_ff;
      res_status_in        = res_status_ff;
      use_rd_in            = use_rd_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_alloc_address_in = rsp_alloc_address_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_free_bytes_in    = rsp_free_bytes_ff;
      mem_req              = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               use_rd_in     = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_RESP;
               case (req_type)
                  REQ_ALLOC: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = SLOT_BITS'(count_ff - 1'b1);
                        count_in      = count_ff - 1'b1;
                        use_rd_in     = 1'b1;
                     end
                  end
                  REQ_FREE: begin
                     if (bad_free) begin
                        res_status_in = ST_BAD;
                     end else if (count_ff >= CNT_BITS'(PAGE_SLOTS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[SLOT_BITS-1:0];
                        mem_req.wdata = req_page_address[ADDR_BITS-1:PAGE_SHIFT];
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  REQ_INIT: begin
                     count_in   = '0;
                     pn_in      = (PN_BITS+1)'(pool_start[ADDR_BITS-1:PAGE_SHIFT]) +
                                  (PN_BITS+1)'(pool_start[PAGE_SHIFT-1:0] != '0);
                     stop_pn_in = (PN_BITS+1)'(pool_stop[ADDR_BITS-1:PAGE_SHIFT]);
                     state_in   = S_INIT_CALC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INIT_CALC: begin
            n_in          = '0;
            res_status_in = ST_OK;
            if (stop_pn_ff > pn_ff) begin
               if (span > (PN_BITS+1)'(PAGE_SLOTS)) begin
                  n_in          = CNT_BITS'(PAGE_SLOTS);
                  res_status_in = ST_FULL;
               end else begin
                  n_in = span[CNT_BITS-1:0];
               end
            end
            state_in = S_INIT_FILL;
         end
         S_INIT_FILL: begin
            if (count_ff == n_ff) begin
               state_in = S_RESP;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = count_ff[SLOT_BITS-1:0];
               mem_req.wdata = pn_ff[PN_BITS-1:0];
               count_in      = count_ff + 1'b1;
               pn_in         = pn_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_alloc_address_in = use_rd_ff ? {mem_rd_data, {PAGE_SHIFT{1'b0}}} : '0;
               rsp_status_in        = res_status_ff;
               rsp_free_bytes_in    = {count_ff, {PAGE_SHIFT{1'b0}}};
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff                 <= n_in;
      pn_ff                <= pn_in;
      stop_pn_ff           <= stop_pn_in;
      res_status_ff        <= res_status_in;
      use_rd_ff            <= use_rd_in;
      rsp_alloc_address_ff <= rsp_alloc_address_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_free_bytes_ff    <= rsp_free_bytes_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alloc_address = rsp_alloc_address_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_bytes    = rsp_free_bytes_ff;
   assign stat.busy         = (state_ff != S_IDLE);
   assign stat.count        = count_ff;

endmodule

`default_nettype wire

// File: design/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// lifo free page list allocator over a stack memory of page numbers
// ----------------------------------------------------------------------------
// usage
//   csr port: pool_start (index 0) and pool_stop (index 1), written while idle
//   req channel: req_type alloc, free or init plus req_page_address for free
//   rsp channel: one transfer per request with alloc_address, status and
//     free_bytes after the request
//   alloc, free and unused codes: the request is taken in the idle step and
//     the response step that follows every request loads the response
//     register once it is free, and the next request is taken back in idle
//   init: a calc step sizes the fill, then a fill step pushes n pages, one
//     stack write per page, before the response step
//   a request is taken while a previous response still waits; a stalled
//     response holds the sequencer in its response step until taken
//   reset clears the page count, the pool registers and the response valid;
//     the stack memory holds no reset state and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module page_free_list_allocator
   import pfla_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_BITS-1:0]   csr_index,
   input  wire logic [ADDR_BITS-1:0]  csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_type,
   input  wire logic [ADDR_BITS-1:0]  req_page_address,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [ADDR_BITS-1:0]       rsp_alloc_address,
   output logic [1:0]                 rsp_status,
   output logic [BYTES_BITS-1:0]      rsp_free_bytes
);

`include "assert_macros.svh"

   logic [ADDR_BITS-1:0] pool_start_ff;
   logic [ADDR_BITS-1:0] pool_stop_ff;
   pfla_mem_req_type     mem_req;
   logic [PN_BITS-1:0]   mem_rd_data;
   pfla_stat_type        stat;
   logic                 rsp_empty;
   logic                 rsp_empty_clean;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff <= '0;
         pool_stop_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POOL_START: pool_start_ff <= csr_wdata;
            CSR_POOL_STOP:  pool_stop_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pfla_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_page_address  (req_page_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_alloc_address (rsp_alloc_address),
      .rsp_status        (rsp_status),
      .rsp_free_bytes    (rsp_free_bytes),
      .pool_start        (pool_start_ff),
      .pool_stop         (pool_stop_ff),
      .mem_req           (mem_req),
      .mem_rd_data       (mem_rd_data),
      .stat              (stat)
   );

   pfla_stack_ram u_stack_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign rsp_empty       = rsp_valid && (rsp_status == ST_EMPTY);
   assign rsp_empty_clean = (rsp_alloc_address == '0) && (rsp_free_bytes == '0);

   `PFLA_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, stat.count <= CNT_BITS'(PAGE_SLOTS))
   `PFLA_ASSERT_IMPL(a_empty_zero_addr, clock, reset, rsp_empty, rsp_empty_clean)
   `PFLA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, stat.busy)
   `PFLA_ASSERT_IMPL(a_no_mem_conflict, clock, reset, mem_req.we, !mem_req.re)

endmodule

`default_nettype wire

// File: sim/tb_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_page_free_list_allocator
// self-checking testbench for the lifo free page list allocator
// ----------------------------------------------------------------------------
// A behavioral copy of the page stack and pool registers predicts alloc
// address, status and free byte count for every accepted request. Responses
// are checked in order, field by field. Directed cases cover empty, small,
// inverted, top-of-memory and oversized pools. Random phases then reprogram
// the pool and run init followed by alloc and free traffic, with random
// gaps on both sides, a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_page_free_list_allocator
   import pfla_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam logic [63:0] PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
   localparam logic [63:0] ADDR_MAX    = (64'd1 << ADDR_BITS) - 64'd1;
   localparam int          SETTLE      = 6;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          PRINT_LIMIT = 30;

   typedef struct packed {
      int unsigned           seq;
      logic [ADDR_BITS-1:0]  alloc_address;
      logic [1:0]            status;
      logic [BYTES_BITS-1:0] free_bytes;
   } reply_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_BITS-1:0]   csr_index;
   logic [ADDR_BITS-1:0]  csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_type;
   logic [ADDR_BITS-1:0]  req_page_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ADDR_BITS-1:0]  rsp_alloc_address;
   logic [1:0]            rsp_status;
   logic [BYTES_BITS-1:0] rsp_free_bytes;

   // predicted allocator state
   logic [PN_BITS-1:0]    page_stack [PAGE_SLOTS];
   int                    page_count = 0;
   logic [ADDR_BITS-1:0]  pool_first = '0;
   logic [ADDR_BITS-1:0]  pool_end   = '0;

   reply_type             replies_due [$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   int                    sender_max_gap = 4;
   int                    rsp_max_stall = 4;
   int                    hold_request = 0;
   int unsigned           request_count = 0;
   int                    alloc_reqs = 0;
   int                    free_reqs = 0;
   int                    init_reqs = 0;
   int                    unused_reqs = 0;
   int                    replies_checked = 0;
   int                    status_seen [4] = '{0, 0, 0, 0};

   page_free_list_allocator u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_page_address  (req_page_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_alloc_address (rsp_alloc_address),
      .rsp_status        (rsp_status),
      .rsp_free_bytes    (rsp_free_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [ADDR_BITS-1:0] rand_addr();
      return ADDR_BITS'({$urandom, $urandom});
   endfunction

   function automatic reply_type allocator_step(input logic [1:0] kind,
                                                input logic [ADDR_BITS-1:0] addr);
      reply_type   r;
      logic [63:0] first_pn;
      logic [63:0] stop_pn;
      logic [63:0] total;
      logic [63:0] n;
      r.seq = request_count;
      r.alloc_address = '0;
      r.status = ST_OK;
      request_count++;
      case (kind)
         REQ_ALLOC: begin
            alloc_reqs++;
            if (page_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               page_count--;
               r.alloc_address = ADDR_BITS'(page_stack[page_count]) << PAGE_SHIFT;
            end
         end
         REQ_FREE: begin
            free_reqs++;
            if (addr[PAGE_SHIFT-1:0] != '0 || addr < pool_first || addr >= pool_end) begin
               r.status = ST_BAD;
            end else if (page_count >= PAGE_SLOTS) begin
               r.status = ST_FULL;
            end else begin
               page_stack[page_count] = addr[ADDR_BITS-1:PAGE_SHIFT];
               page_count++;
            end
         end
         REQ_INIT: begin
            init_reqs++;
            first_pn = (64'(pool_first) >> PAGE_SHIFT) +
                       64'(pool_first[PAGE_SHIFT-1:0] != '0);
            stop_pn = 64'(pool_end) >> PAGE_SHIFT;
            total = (stop_pn > first_pn) ? stop_pn - first_pn : 64'd0;
            n = (total > PAGE_SLOTS) ? 64'(PAGE_SLOTS) : total;
            for (longint unsigned i = 0; i < n; i++)
               page_stack[i] = PN_BITS'(first_pn + i);
            page_count = int'(n);
            if (total > PAGE_SLOTS) r.status = ST_FULL;
         end
         default: begin
            unused_reqs++;
         end
      endcase
      r.free_bytes = BYTES_BITS'(page_count << PAGE_SHIFT);
      status_seen[r.status]++;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned seq,
                                  input logic [63:0] got, input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on request %0d: %s got %h want %h", seq, what, got, want);
      mismatch_count++;
   endtask

   // response side: random stalls per transfer, long hold-off on request
   initial begin : reply_sink
      int        stall_left;
      int        hold_left;
      reply_type due;
      stall_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            replies_checked++;
            if (replies_due.size() == 0) begin
               report_mismatch("response with none due", 0,
                               64'(rsp_alloc_address), 64'd0);
            end else begin
               due = replies_due.pop_front();
               if (rsp_alloc_address !== due.alloc_address)
                  report_mismatch("alloc_address", due.seq,
                                  64'(rsp_alloc_address), 64'(due.alloc_address));
               if (rsp_status !== due.status)
                  report_mismatch("status", due.seq, 64'(rsp_status), 64'(due.status));
               if (rsp_free_bytes !== due.free_bytes)
                  report_mismatch("free_bytes", due.seq,
                                  64'(rsp_free_bytes), 64'(due.free_bytes));
            end
            stall_left = $urandom_range(0, rsp_max_stall);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one request transfer; valid stays high on return
   task automatic send_req(input logic [1:0] kind, input logic [ADDR_BITS-1:0] addr,
                           output reply_type due);
      int gap;
      gap = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_page_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due = allocator_step(kind, addr);
      replies_due.push_back(due);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // only while idle
   task automatic set_pool(input logic [ADDR_BITS-1:0] lo, input logic [ADDR_BITS-1:0] hi);
      csr_we <= 1'b1;
      csr_index <= CSR_POOL_START;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_POOL_STOP;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      pool_first = lo;
      pool_end = hi;
   endtask

   task automatic test_reset_state();
      reply_type r;
      send_req(REQ_ALLOC, '0, r);
      send_req(REQ_FREE, '0, r);
      send_req(REQ_INIT, rand_addr(), r);
      send_req(REQ_UNUSED, '1, r);
   endtask

   task automatic test_small_pool();
      reply_type r;
      drain_replies();
      set_pool(56'h1234, 56'h5800);
      send_req(REQ_INIT, '0, r);
      send_req(REQ_ALLOC, '0, r);
      send_req(REQ_FREE, 56'h4000, r);
      send_req(REQ_FREE, 56'h4001, r);
      send_req(REQ_FREE, 56'h1000, r);
      send_req(REQ_FREE, 56'h6000, r);
      send_req(REQ_FREE, 56'h5000, r);
      repeat (5) send_req(REQ_ALLOC, rand_addr(), r);
      // inverted pool
      drain_replies();
      set_pool(56'h1_0000, 56'h8000);
      send_req(REQ_INIT, '0, r);
      send_req(REQ_ALLOC, '0, r);
   endtask

   task automatic test_top_of_memory();
      reply_type r;
      drain_replies();
      set_pool(56'hFF_FFFF_FFFF_C000, 56'hFF_FFFF_FFFF_FFFF);
      send_req(REQ_INIT, '0, r);
      send_req(REQ_ALLOC, '0, r);
      send_req(REQ_FREE, 56'hFF_FFFF_FFFF_F000, r);
      send_req(REQ_FREE, 56'hFF_FFFF_FFFF_FFFF, r);
   endtask

   task automatic test_oversized_pool();
      reply_type r;
      drain_replies();
      set_pool('0, '1);
      send_req(REQ_INIT, '0, r);
      send_req(REQ_FREE, '0, r);
      send_req(REQ_ALLOC, '0, r);
      send_req(REQ_FREE, r.alloc_address, r);
      send_req(REQ_FREE, 56'h80_0000_0000_0000, r);
   endtask

   task automatic run_pool_phase(input int n_ops, input int max_pages);
      logic [63:0]          lo;
      logic [63:0]          hi;
      logic [63:0]          swap;
      logic [ADDR_BITS-1:0] a;
      logic [ADDR_BITS-1:0] handed_out [$];
      int                   pages;
      int                   pick;
      int                   slot;
      reply_type            r;
      drain_replies();
      sender_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
      rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 4;
      pages = $urandom_range(0, max_pages);
      lo = 64'(rand_addr());
      if ($urandom_range(0, 1)) lo[PAGE_SHIFT-1:0] = '0;
      hi = lo + 64'(pages) * PAGE_BYTES + 64'($urandom_range(0, 4095));
      if (hi > ADDR_MAX) hi = ADDR_MAX;
      if ($urandom_range(0, 9) == 0) begin
         swap = lo;
         lo = hi;
         hi = swap;
      end
      set_pool(ADDR_BITS'(lo), ADDR_BITS'(hi));
      send_req(REQ_INIT, rand_addr(), r);
      repeat (n_ops) begin
         pick = $urandom_range(0, 99);
         if (pick < 66 && pick >= 38 && handed_out.size() != 0) begin
            slot = $urandom_range(0, handed_out.size() - 1);
            a = handed_out[slot];
            handed_out.delete(slot);
            send_req(REQ_FREE, a, r);
         end else if (pick < 66) begin
            send_req(REQ_ALLOC, rand_addr(), r);
            if (r.status == ST_OK) handed_out.push_back(r.alloc_address);
         end else if (pick < 74) begin
            a = ADDR_BITS'((((lo + PAGE_BYTES - 64'd1) >> PAGE_SHIFT) +
                            64'($urandom_range(0, pages + 1))) << PAGE_SHIFT);
            send_req(REQ_FREE, a, r);
         end else if (pick < 90) begin
            case ($urandom_range(0, 3))
               0: a = rand_addr();
               1: a = ADDR_BITS'(lo) | ADDR_BITS'($urandom_range(1, 4095));
               2: a = (ADDR_BITS'(lo) - ADDR_BITS'(PAGE_BYTES)) & ~ADDR_BITS'(PAGE_BYTES - 1);
               default: a = ADDR_BITS'((hi + PAGE_BYTES - 64'd1) & ~(PAGE_BYTES - 64'd1));
            endcase
            send_req(REQ_FREE, a, r);
         end else if (pick < 95) begin
            send_req(REQ_INIT, rand_addr(), r);
            handed_out.delete();
         end else begin
            send_req(REQ_UNUSED, rand_addr(), r);
         end
      end
   endtask

   task automatic test_random_pools(input int phases);
      for (int p = 0; p < phases; p++)
         run_pool_phase(64, (p % 6 == 3) ? 6000 : 48);
      sender_max_gap = 4;
      rsp_max_stall = 4;
   endtask

   // responses held back long enough for the request side to back up
   task automatic test_response_backlog();
      reply_type r;
      drain_replies();
      sender_max_gap = 0;
      set_pool(56'h40_0000, 56'h48_0000);
      send_req(REQ_INIT, '0, r);
      hold_request = 300;
      repeat (30) begin
         send_req(REQ_ALLOC, rand_addr(), r);
         send_req(REQ_FREE, r.alloc_address, r);
      end
      sender_max_gap = 4;
   endtask

   task automatic test_sender_pause();
      reply_type r;
      repeat (10) send_req(REQ_ALLOC, rand_addr(), r);
      drain_replies();
      repeat (10) send_req(REQ_FREE, 56'h40_0000 + ADDR_BITS'($urandom_range(0, 127)) *
                           ADDR_BITS'(PAGE_BYTES), r);
   endtask

   initial begin : test_sequence
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_ALLOC;
      req_page_address <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_POOL_START;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_small_pool();
      test_top_of_memory();
      test_oversized_pool();
      test_random_pools(13);
      test_response_backlog();
      test_sender_pause();
      drain_replies();
      $display("%0d requests: %0d alloc, %0d free, %0d init, %0d unused code",
               request_count, alloc_reqs, free_reqs, init_reqs, unused_reqs);
      $display("%0d responses checked; status ok %0d, pool empty %0d, bad free %0d, full %0d",
               replies_checked, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
